// ===== design/clhf_pkg.sv =====
// clhf_pkg: shared types and constants for the csv line to hex frame block
// no dependencies; imported by every module of the block

package clhf_pkg;

  localparam int unsigned LineMaxDef = 128;

  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam logic [1:0]  ModeCan  = 2'd1;
  localparam logic [11:0] FrameIdRst = 12'h123;
  localparam logic [16:0] AccCap   = 17'h1FFFF;

  // number of characters in one frame, including the closing cr
  localparam int unsigned FrameChars = 12;

  // one committed frame waiting to be printed
  typedef struct packed {
    logic [11:0] frame_id;
    logic [15:0] rpm;
    logic [7:0]  speed;
    logic [7:0]  throttle;
  } frame_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h37 + {4'h0, nib};
    end
    return ch;
  endfunction

endpackage

// ===== design/csv_line_to_hex_frame_top.sv =====
// csv_line_to_hex_frame_top: top level of the csv line to hex frame block
// depends on clhf_pkg, clhf_front, clhf_queue and clhf_back
//
// Usage:
// - slave stream carries one received serial byte per transaction, with the
//   link, forwarding and mode flags alongside; bytes are dropped while the link
//   is down. a newline ends a line of up to three comma-separated decimals
// - on newline with forwarding on and the mode set to CAN, a frame of twelve
//   characters goes out on the master stream: id (3 hex), rpm (4), speed (2),
//   throttle (2), then CR with tlast high
// - the cfg channel writes the 12-bit frame id; it is always ready
// Timing:
// - one input byte is taken every cycle while the frame queue has room
// - after its newline is taken, the first frame character goes through the queue
//   entry and then the output register, and a frame drains at one character per
//   cycle while the receiver is ready; the two-entry queue lets the parser run ahead
// - when the receiver stalls, the output register holds its character and
//   the queue fills; once it holds two frames s_axis_tready drops
// - reset clears the parser, held values (zero) and queue; frame id is 0x123

module csv_line_to_hex_frame_top import clhf_pkg::*; #(
  parameter int unsigned LINE_MAX = LineMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rx_byte [7:0], link_up [8], forwarding_on [9], protocol_mode [11:10], zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_char [7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i
);

  logic   in_fire, push, full, pop, head_valid;
  frame_t push_frame, head;

  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && !full;
  assign cfg_ready_o   = 1'b1;

  clhf_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_fire_i       (in_fire),
    .rx_byte_i       (s_axis_tdata[7:0]),
    .link_up_i       (s_axis_tdata[8]),
    .forwarding_on_i (s_axis_tdata[9]),
    .protocol_mode_i (s_axis_tdata[11:10]),
    .cfg_fire_i      (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .push_o          (push),
    .frame_o         (push_frame)
  );

  clhf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_frame),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  clhf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== design/clhf_front.sv =====
// clhf_front: byte parser for the incoming csv lines and the held values
// depends on clhf_pkg; pushes one frame_t per printable newline

module clhf_front import clhf_pkg::*; #(
  parameter int unsigned LINE_MAX = LineMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_fire_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        link_up_i,
  input  logic        forwarding_on_i,
  input  logic [1:0]  protocol_mode_i,
  input  logic        cfg_fire_i,
  input  logic [11:0] cfg_data_i,
  output logic        push_o,
  output frame_t      frame_o
);

  localparam int unsigned LenW = $clog2(LINE_MAX);
  localparam logic [LenW-1:0] LenLast = LenW'(LINE_MAX - 1);

  typedef enum logic [3:0] {
    PhSkip   = 4'b0001,
    PhSign   = 4'b0010,
    PhDigits = 4'b0100,
    PhDone   = 4'b1000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] len_q, len_d;
  logic [1:0]      fnum_q, fnum_d;
  logic [16:0]     acc_q, acc_d;
  logic            neg_q, neg_d;
  logic [15:0]     rpm_q, rpm_d;
  logic [7:0]      spd_q, spd_d;
  logic [7:0]      thr_q, thr_d;
  logic [15:0]     pend0_q, pend0_d;
  logic [7:0]      pend1_q, pend1_d;
  logic [7:0]      pend2_q, pend2_d;
  logic [11:0]     fid_q;

  logic        is_ws, is_dig, fin;
  logic [20:0] acc_mul;
  logic [16:0] acc_next;
  logic [15:0] fval;
  logic [15:0] p0;
  logic [7:0]  p1, p2;
  logic [2:0]  fcnt;

  assign is_ws  = (rx_byte_i == 8'h20) || (rx_byte_i >= 8'h09 && rx_byte_i <= 8'h0D);
  assign is_dig = (rx_byte_i >= 8'h30) && (rx_byte_i <= 8'h39);

  // acc * 10 + digit, saturated
  assign acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                 + {17'h0, rx_byte_i[3:0]};

  // value of the field being finished, clamped to its digit width
  always_comb begin
    if (neg_q) begin
      fval = '0;
    end else if (fnum_q == 2'd0) begin
      fval = (acc_q > 17'h0FFFF) ? 16'hFFFF : acc_q[15:0];
    end else begin
      fval = (acc_q > 17'h000FF) ? 16'h00FF : {8'h00, acc_q[7:0]};
    end
  end

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    fnum_d  = fnum_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    rpm_d   = rpm_q;
    spd_d   = spd_q;
    thr_d   = thr_q;
    pend0_d = pend0_q;
    pend1_d = pend1_q;
    pend2_d = pend2_q;
    push_o  = 1'b0;
    fin     = 1'b0;
    acc_next = (acc_mul > {4'h0, AccCap}) ? AccCap : acc_mul[16:0];
    p0 = pend0_q;
    p1 = pend1_q;
    p2 = pend2_q;
    fcnt = {1'b0, fnum_q};

    if (in_fire_i && link_up_i) begin
      if (rx_byte_i == CharNl) begin
        // commit converted fields, the one in progress included
        if (phase_q == PhDigits && fnum_q != 2'd3) begin
          fcnt = {1'b0, fnum_q} + 3'd1;
          case (fnum_q)
            2'd0:    p0 = fval;
            2'd1:    p1 = fval[7:0];
            default: p2 = fval[7:0];
          endcase
        end
        if (fcnt > 3'd0) rpm_d = p0;
        if (fcnt > 3'd1) spd_d = p1;
        if (fcnt > 3'd2) thr_d = p2;
        len_d   = '0;
        phase_d = PhSkip;
        fnum_d  = '0;
        acc_d   = '0;
        neg_d   = 1'b0;
        push_o  = forwarding_on_i && (protocol_mode_i == ModeCan);
      end else if (len_q < LenLast) begin
        len_d = len_q + 1'b1;
        if (rx_byte_i == CharNul) begin
          fin     = (phase_q == PhDigits);
          phase_d = PhDone;
        end else begin
          unique case (phase_q)
            PhSkip: begin
              if (is_ws) begin
                phase_d = PhSkip;
              end else if (rx_byte_i == CharPlus || rx_byte_i == CharMinus) begin
                neg_d   = (rx_byte_i == CharMinus);
                phase_d = PhSign;
              end else if (is_dig) begin
                acc_d   = {13'h0, rx_byte_i[3:0]};
                phase_d = PhDigits;
              end else begin
                phase_d = PhDone;
              end
            end
            PhSign: begin
              if (is_dig) begin
                acc_d   = {13'h0, rx_byte_i[3:0]};
                phase_d = PhDigits;
              end else begin
                phase_d = PhDone;
              end
            end
            PhDigits: begin
              if (is_dig) begin
                acc_d = acc_next;
              end else begin
                fin = 1'b1;
                // after finishing, fnum_q + 1 fields are done
                if (fnum_q < 2'd2 && rx_byte_i == CharComma) begin
                  phase_d = PhSkip;
                end else begin
                  phase_d = PhDone;
                end
              end
            end
            PhDone: phase_d = PhDone;
            default: phase_d = PhDone;
          endcase
        end
        if (fin && fnum_q != 2'd3) begin
          case (fnum_q)
            2'd0:    pend0_d = fval;
            2'd1:    pend1_d = fval[7:0];
            default: pend2_d = fval[7:0];
          endcase
          fnum_d = fnum_q + 1'b1;
          acc_d  = '0;
          neg_d  = 1'b0;
        end
      end else begin
        // overflowing byte is lost and the line starts over
        len_d   = '0;
        phase_d = PhSkip;
        fnum_d  = '0;
        acc_d   = '0;
        neg_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      len_q   <= '0;
      fnum_q  <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      rpm_q   <= '0;
      spd_q   <= '0;
      thr_q   <= '0;
      fid_q   <= FrameIdRst;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      fnum_q  <= fnum_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      rpm_q   <= rpm_d;
      spd_q   <= spd_d;
      thr_q   <= thr_d;
      if (cfg_fire_i) fid_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pend0_q <= pend0_d;
    pend1_q <= pend1_d;
    pend2_q <= pend2_d;
  end

  assign frame_o = '{frame_id: fid_q, rpm: rpm_d, speed: spd_d, throttle: thr_d};

endmodule

// ===== design/clhf_queue.sv =====
// clhf_queue: two-entry frame queue between parser and serializer
// depends on clhf_pkg for frame_t

module clhf_queue import clhf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output frame_t head_o
);

  frame_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

endmodule

// ===== design/clhf_back.sv =====
// clhf_back: prints the head frame as twelve ascii characters
// depends on clhf_pkg; output register toward the stream receiver

module clhf_back import clhf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  frame_t     head_i,
  output logic       pop_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast
);

  localparam logic [3:0] IdxLast = 4'(FrameChars - 1);

  logic [3:0]  idx_q;
  logic        ovld_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic        load;
  logic [43:0] digits, shifted;
  logic [7:0]  next_char;

  assign load   = head_valid_i && (!ovld_q || m_axis_tready);
  assign pop_o  = load && (idx_q == IdxLast);
  assign digits = head_i;
  // most significant nibble first
  assign shifted = digits >> {(4'd10 - idx_q), 2'b00};
  assign next_char = (idx_q == IdxLast) ? CharCr : hex_char(shifted[3:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      if (load) begin
        ovld_q <= 1'b1;
        idx_q  <= (idx_q == IdxLast) ? 4'd0 : idx_q + 4'd1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= next_char;
      last_q <= (idx_q == IdxLast);
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = char_q;
  assign m_axis_tlast  = last_q;

endmodule

// ===== sim/tb_csv_line_to_hex_frame_top.sv =====
`timescale 1ns / 1ps
// tb_csv_line_to_hex_frame_top: self-checking bench for the csv line to hex frame block
// drives text lines and noise on the slave stream, predicts each frame character in a
// scoreboard class and checks the master stream; depends on clhf_pkg and the rtl

module tb_csv_line_to_hex_frame_top;
  import clhf_pkg::*;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned ResetCycles   = 4;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseItems    = 70;

  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeObd   = 2'd2;
  localparam logic [1:0] ModeSpare = 2'd3;

  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharVt    = 8'h0B;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSemi  = 8'h3B;

  typedef enum logic [1:0] {PhSkip, PhSign, PhDigits, PhDone} scan_phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } frame_char_t;

  class frame_scoreboard;
    logic [11:0]   frame_id;
    int unsigned   line_len;
    scan_phase_e   phase;
    int unsigned   fields;
    int unsigned   magnitude;
    bit            negative;
    logic [15:0]   rpm;
    logic [7:0]    speed;
    logic [7:0]    throttle;
    int unsigned   pending [3];
    frame_char_t   frame_chars_q [$];
    int unsigned   errors;

    function new();
      frame_id = FrameIdRst;
      line_len = 0;
      rpm      = '0;
      speed    = '0;
      throttle = '0;
      pending  = '{0, 0, 0};
      errors   = 0;
      restart_scan();
    endfunction

    function void set_frame_id(logic [11:0] v);
      frame_id = v;
    endfunction

    function void restart_scan();
      phase     = PhSkip;
      fields    = 0;
      magnitude = 0;
      negative  = 1'b0;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CharSpace || (c >= CharTab && c <= CharCr);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CharZero && c <= 8'h39;
    endfunction

    function void add_digit(logic [7:0] c);
      int unsigned v;
      v = magnitude * 10 + (c - CharZero);
      magnitude = (v > AccCap) ? AccCap : v;
    endfunction

    // rpm clips at 16 bits, speed and throttle at 8; a negative number reads as zero
    function void close_field();
      int unsigned cap;
      int unsigned v;
      cap = (fields == 0) ? 32'hFFFF : 32'hFF;
      v = negative ? 0 : magnitude;
      if (v > cap) v = cap;
      if (fields < 3) begin
        pending[fields] = v;
        fields++;
      end
      magnitude = 0;
      negative  = 1'b0;
    endfunction

    function void scan_char(logic [7:0] c);
      case (phase)
        PhSkip: begin
          if (!is_space(c)) begin
            if (c == CharPlus || c == CharMinus) begin
              negative = (c == CharMinus);
              phase = PhSign;
            end else if (is_digit(c)) begin
              magnitude = 0;
              add_digit(c);
              phase = PhDigits;
            end else begin
              phase = PhDone;
            end
          end
        end
        PhSign: begin
          if (is_digit(c)) begin
            magnitude = 0;
            add_digit(c);
            phase = PhDigits;
          end else begin
            phase = PhDone;
          end
        end
        PhDigits: begin
          if (is_digit(c)) begin
            add_digit(c);
          end else begin
            close_field();
            phase = (fields < 3 && c == CharComma) ? PhSkip : PhDone;
          end
        end
        default: ;
      endcase
    endfunction

    function void push_hex(logic [15:0] v, int digits);
      string hex_digits = "0123456789ABCDEF";
      logic [3:0] nib;
      for (int i = digits - 1; i >= 0; i--) begin
        nib = v[4*i +: 4];
        frame_chars_q.push_back('{ch: hex_digits[nib], last: 1'b0});
      end
    endfunction

    // one accepted slave transaction: rx_byte, link_up, forwarding_on, protocol_mode
    function void note_input(logic [15:0] word);
      logic [7:0] c;
      logic       up;
      logic       fwd;
      logic [1:0] mode;
      c    = word[7:0];
      up   = word[8];
      fwd  = word[9];
      mode = word[11:10];
      if (!up) return;
      if (c == CharNl) begin
        if (phase == PhDigits) close_field();
        if (fields > 0) rpm = 16'(pending[0]);
        if (fields > 1) speed = 8'(pending[1]);
        if (fields > 2) throttle = 8'(pending[2]);
        line_len = 0;
        restart_scan();
        if (fwd && mode == ModeCan) begin
          push_hex({4'h0, frame_id}, 3);
          push_hex(rpm, 4);
          push_hex({8'h00, speed}, 2);
          push_hex({8'h00, throttle}, 2);
          frame_chars_q.push_back('{ch: CharCr, last: 1'b1});
        end
      end else if (line_len < LineMaxDef - 1) begin
        line_len++;
        if (c == CharNul) begin
          if (phase == PhDigits) close_field();
          phase = PhDone;
        end else begin
          scan_char(c);
        end
      end else begin
        // line full: this byte is lost and the scan starts over
        line_len = 0;
        restart_scan();
      end
    endfunction

    function void check_result(logic [7:0] ch, logic last);
      frame_char_t want;
      if (frame_chars_q.size() == 0) begin
        $error("unexpected transaction: tx_char %h last %b", ch, last);
        errors++;
        return;
      end
      want = frame_chars_q.pop_front();
      if (ch !== want.ch) begin
        $error("tx_char mismatch: expected %h, actual %h", want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %b, actual %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [11:0] cfg_data_i;

  frame_scoreboard board = new();

  logic        line_up;
  logic        line_fwd;
  logic [1:0]  line_mode;
  bit          link_flaky;
  bit          calm;
  bit          hold_req;
  int unsigned bytes_sent;
  int unsigned idle_cycles;

  csv_line_to_hex_frame_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 4))
      0: return CharSpace;
      1: return CharTab;
      2: return CharVt;
      3: return CharFf;
      default: return CharCr;
    endcase
  endfunction

  function automatic logic [7:0] pick_csv_char();
    int unsigned r;
    r = $urandom_range(0, 11);
    if (r < 8) return CharZero + 8'($urandom_range(0, 9));
    if (r < 10) return CharComma;
    if (r < 11) return CharSpace;
    return CharMinus;
  endfunction

  task automatic set_flags(input logic up, input logic fwd, input logic [1:0] mode);
    line_up   = up;
    line_fwd  = fwd;
    line_mode = mode;
  endtask

  task automatic send_byte(input logic [7:0] c);
    int unsigned gap;
    logic        up;
    gap = pick_gap();
    up = line_up & ~(link_flaky & ($urandom_range(0, 7) == 0));
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'h0, line_mode, line_fwd, up, c};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    board.note_input(s_axis_tdata);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_number();
    int unsigned ndigits;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) send_byte(pick_space());
    case ($urandom_range(0, 7))
      0: send_byte(CharMinus);
      1: send_byte(CharPlus);
      default: ;
    endcase
    ndigits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    repeat (ndigits) send_byte(CharZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic send_random_line();
    int unsigned kind;
    int unsigned nfields;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) begin
      set_flags(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                2'($urandom_range(0, 3)));
    end else begin
      set_flags(1'b1, 1'b1, ModeCan);
    end
    link_flaky = ($urandom_range(0, 9) == 0);
    if (kind < 75) begin
      nfields = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 3;
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) send_byte(CharComma);
        send_number();
      end
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      repeat ($urandom_range(0, 16)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      // record whose second field is a negative number or breaks off at a semicolon
      send_number();
      send_byte(CharComma);
      send_byte($urandom_range(0, 1) ? CharMinus : CharSemi);
      send_number();
    end
    send_byte(CharNl);
    link_flaky = 1'b0;
  endtask

  // runs up to and just past the line buffer limit
  task automatic send_long_line();
    set_flags(1'b1, 1'b1, ModeCan);
    repeat (LineMaxDef - 2 + $urandom_range(0, 4)) send_byte(pick_csv_char());
    send_byte(CharNl);
  endtask

  task automatic run_phase(input int unsigned items, input bit squeeze);
    int unsigned start;
    bit          held;
    start = bytes_sent;
    held  = 1'b0;
    while (bytes_sent - start < items) begin
      if (squeeze && !held && bytes_sent - start > 20) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      send_random_line();
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.frame_chars_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_frame_id(input logic [11:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    board.set_frame_id(v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      board.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receive side: random stalls plus one long hold-off on request
  initial begin : rx_side
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HoldCycles;
      end else begin
        stall = pick_gap();
      end
      m_axis_tready = (stall == 0);
      repeat (stall) @(negedge clk_i);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    link_flaky    = 1'b0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    bytes_sent    = 0;
    idle_cycles   = 0;
    set_flags(1'b1, 1'b1, ModeCan);
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty line with reset id, then whitespace, signs, clipping
    send_byte(CharNl);
    send_text(" \t+7,-5,300\n");
    send_text("999999,-\n");
    // nul ends the scan after the first number
    send_byte(8'h34);
    send_byte(CharNul);
    send_byte(8'h32);
    send_byte(CharNl);
    set_flags(1'b0, 1'b1, ModeCan);
    send_byte(CharNl);
    set_flags(1'b1, 1'b0, ModeCan);
    send_byte(CharNl);
    set_flags(1'b1, 1'b1, ModeIdle);
    send_byte(CharNl);
    set_flags(1'b1, 1'b1, ModeObd);
    send_byte(CharNl);
    set_flags(1'b1, 1'b1, ModeSpare);
    send_byte(CharNl);
    wait_drained();

    write_frame_id(12'hFFF);
    run_phase(PhaseItems, 1'b1);
    send_long_line();
    wait_drained();

    write_frame_id(12'h000);
    calm = 1'b1;
    run_phase(PhaseItems, 1'b0);
    calm = 1'b0;
    wait_drained();

    write_frame_id(12'($urandom_range(1, 4094)));
    run_phase(PhaseItems, 1'b0);
    send_long_line();
    wait_drained();

    if (board.errors == 0 && board.frame_chars_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
